### design/rwcl_pkg.sv
// Package for the RIFF/WAVE chunk locator: parser phases, tags, status codes, result struct.
`default_nettype none

package rwcl_pkg;

  // RIFF words as they read little-endian
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;

  // status codes reported on the result channel
  localparam logic [1:0] ST_SCAN    = 2'd0;
  localparam logic [1:0] ST_FOUND   = 2'd1;
  localparam logic [1:0] ST_BAD_TAG = 2'd2;
  localparam logic [1:0] ST_EXHAUST = 2'd3;

  // parser phase
  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_LEN  = 3'd1,
    PH_WAVE = 3'd2,
    PH_TAG  = 3'd3,
    PH_SIZE = 3'd4,
    PH_SKIP = 3'd5,
    PH_DONE = 3'd6
  } rwcl_phase_t;

  // what the parser shows after the latest byte
  typedef struct packed {
    logic        data_valid;
    logic        fmt_valid;
    logic [31:0] data_offset;
    logic [31:0] fmt_offset;
    logic [1:0]  status;
  } rwcl_result_t;

endpackage

`default_nettype wire

### design/rwcl_parser.sv
// Byte-wise RIFF/WAVE header and chunk walker; state registers double as the result.
`default_nettype none

module rwcl_parser import rwcl_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,        // a byte beat is taken this cycle
  input  wire logic [7:0]   data_byte,
  input  wire logic         first_byte,
  output rwcl_result_t      res
);

  rwcl_phase_t phase_r, phase_nxt, phase_b;
  logic [1:0]  biw_r, biw_nxt, biw_b;
  logic [31:0] shift_r, shift_nxt, shift_b;
  logic [31:0] rem_r, rem_nxt, rem_b;
  logic [31:0] skip_r, skip_nxt, skip_b;
  logic [31:0] pos_r, pos_nxt, pos_b;
  logic [31:0] fmt_pos_r, fmt_pos_nxt, fmt_pos_b;
  logic [31:0] data_pos_r, data_pos_nxt, data_pos_b;
  logic        fmt_seen_r, fmt_seen_nxt, fmt_seen_b;
  logic        data_seen_r, data_seen_nxt, data_seen_b;
  logic [1:0]  verdict_r, verdict_nxt, verdict_b;

  logic [31:0] word;
  logic [31:0] rem_sub;
  logic [31:0] skip_dec;
  logic [31:0] hdr_pos;
  logic        fmt_hit;
  logic        data_hit;

  // a first byte starts from the reset state
  always_comb begin
    if (first_byte) begin
      phase_b     = PH_RIFF;
      biw_b       = '0;
      shift_b     = '0;
      rem_b       = '0;
      skip_b      = '0;
      pos_b       = '0;
      fmt_pos_b   = '0;
      data_pos_b  = '0;
      fmt_seen_b  = 1'b0;
      data_seen_b = 1'b0;
      verdict_b   = ST_SCAN;
    end else begin
      phase_b     = phase_r;
      biw_b       = biw_r;
      shift_b     = shift_r;
      rem_b       = rem_r;
      skip_b      = skip_r;
      pos_b       = pos_r;
      fmt_pos_b   = fmt_pos_r;
      data_pos_b  = data_pos_r;
      fmt_seen_b  = fmt_seen_r;
      data_seen_b = data_seen_r;
      verdict_b   = verdict_r;
    end
  end

  // datapath pieces shared by the phase decode
  assign word     = {data_byte, shift_b[31:8]};
  assign rem_sub  = rem_b - word;
  assign skip_dec = skip_b - 32'd1;
  assign hdr_pos  = pos_b - 32'd3;
  assign fmt_hit  = (word == TAG_FMT);
  assign data_hit = (word == TAG_DATA);

  // next state
  always_comb begin
    phase_nxt     = phase_b;
    biw_nxt       = biw_b;
    shift_nxt     = shift_b;
    rem_nxt       = rem_b;
    skip_nxt      = skip_b;
    pos_nxt       = pos_b;
    fmt_pos_nxt   = fmt_pos_b;
    data_pos_nxt  = data_pos_b;
    fmt_seen_nxt  = fmt_seen_b;
    data_seen_nxt = data_seen_b;
    verdict_nxt   = verdict_b;
    if (phase_b != PH_DONE) begin
      pos_nxt = pos_b + 32'd1;
      if (phase_b == PH_SKIP) begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = PH_TAG;
        end
      end else begin
        shift_nxt = word;
        biw_nxt   = biw_b + 2'd1;
        // word complete on the fourth byte
        if (biw_b == 2'd3) begin
          case (phase_b)
            PH_RIFF: begin
              if (word != TAG_RIFF) begin
                verdict_nxt = ST_BAD_TAG;
                phase_nxt   = PH_DONE;
              end else begin
                phase_nxt = PH_LEN;
              end
            end
            PH_LEN: begin
              rem_nxt   = word;
              phase_nxt = PH_WAVE;
            end
            PH_WAVE: begin
              if (word != TAG_WAVE) begin
                verdict_nxt = ST_BAD_TAG;
                phase_nxt   = PH_DONE;
              end else if (rem_b == '0 || rem_b[31]) begin
                verdict_nxt = ST_EXHAUST;
                phase_nxt   = PH_DONE;
              end else begin
                phase_nxt = PH_TAG;
              end
            end
            PH_TAG: begin
              if (fmt_hit) begin
                fmt_pos_nxt  = hdr_pos;
                fmt_seen_nxt = 1'b1;
              end else if (data_hit) begin
                data_pos_nxt  = hdr_pos;
                data_seen_nxt = 1'b1;
              end
              if ((fmt_seen_b || fmt_hit) && (data_seen_b || (data_hit && !fmt_hit))) begin
                verdict_nxt = ST_FOUND;
                phase_nxt   = PH_DONE;
              end else begin
                phase_nxt = PH_SIZE;
              end
            end
            PH_SIZE: begin
              rem_nxt  = rem_sub;
              skip_nxt = word;
              if (rem_sub == '0 || rem_sub[31]) begin
                verdict_nxt = ST_EXHAUST;
                phase_nxt   = PH_DONE;
              end else if (word == '0) begin
                phase_nxt = PH_TAG;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
            default: begin
              verdict_nxt = ST_EXHAUST;
              phase_nxt   = PH_DONE;
            end
          endcase
        end
      end
    end
  end

  // state registers, loaded once per byte beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RIFF;
      biw_r       <= '0;
      shift_r     <= '0;
      rem_r       <= '0;
      skip_r      <= '0;
      pos_r       <= '0;
      fmt_pos_r   <= '0;
      data_pos_r  <= '0;
      fmt_seen_r  <= 1'b0;
      data_seen_r <= 1'b0;
      verdict_r   <= ST_SCAN;
    end else if (step) begin
      phase_r     <= phase_nxt;
      biw_r       <= biw_nxt;
      shift_r     <= shift_nxt;
      rem_r       <= rem_nxt;
      skip_r      <= skip_nxt;
      pos_r       <= pos_nxt;
      fmt_pos_r   <= fmt_pos_nxt;
      data_pos_r  <= data_pos_nxt;
      fmt_seen_r  <= fmt_seen_nxt;
      data_seen_r <= data_seen_nxt;
      verdict_r   <= verdict_nxt;
    end
  end

  // result view
  always_comb begin
    res.status      = verdict_r;
    res.fmt_offset  = fmt_pos_r;
    res.data_offset = data_pos_r;
    res.fmt_valid   = fmt_seen_r;
    res.data_valid  = data_seen_r;
  end

  // a verdict other than scanning parks the parser
  a_verdict_done: assert property (@(posedge clk) disable iff (!rst_n)
    (verdict_r != ST_SCAN) |-> (phase_r == PH_DONE))
    else $error("verdict set while parser still running");

  // found means both chunk headers were recorded
  a_found_both: assert property (@(posedge clk) disable iff (!rst_n)
    (verdict_r == ST_FOUND) |-> (fmt_seen_r && data_seen_r))
    else $error("found reported without both chunks");

  // a skip never starts with an empty count
  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP) |-> (skip_r != '0))
    else $error("skip phase with zero count");

  // a parked parser does not move on a non-first byte
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !first_byte && phase_r == PH_DONE) |=> $stable(pos_r))
    else $error("byte position moved after verdict");

endmodule

`default_nettype wire

### design/riff_wave_chunk_locator.sv
// Top level of the RIFF/WAVE chunk locator: stream handshake around the byte parser.
//
//  channel | dir | payload (low bit up)                                   | beat
//  in_     | in  | tdata: data_byte[7:0]; tuser: first_byte[0]            | one file byte
//  out_    | out | tdata: status[1:0] fmt_offset[33:2] data_offset[65:34] | one per input
//          |     |        fmt_valid[66] data_valid[67], zero fill to 72   |
//
// One result per byte, registered from the byte beat; a byte beat is taken every
// cycle while the result register is empty or being drained. The parser state
// registers hold the result, so a stall on out_ only holds in_tready low.
// Reset (rst_n, synchronous) empties the result register and puts the parser in
// the RIFF tag phase, as though the next byte were marked first.
`default_nettype none

module riff_wave_chunk_locator import rwcl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte[7:0]
  input  wire logic [0:0]  in_tuser,   // first_byte[0]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [71:0] out_tdata   // status, fmt_offset, data_offset, fmt_valid, data_valid
);

  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         step;
  rwcl_result_t res;

  // take a byte when the result slot is free or emptying now
  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  rwcl_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .data_byte  (in_tdata),
    .first_byte (in_tuser[0]),
    .res        (res)
  );

  // result slot occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res};

  // a byte beat always leaves a result waiting
  a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("byte taken without a result");

  // a result that is not taken and has no successor stays put
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> ($stable(out_tdata) && out_valid_r))
    else $error("pending result changed");

  // no byte is taken over a stalled result
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !step)
    else $error("byte taken while result stalled");

endmodule

`default_nettype wire

### sim/tb_riff_wave_chunk_locator.sv
// Testbench for the RIFF/WAVE chunk locator: byte streams in, each result checked against a predictor.
module tb_riff_wave_chunk_locator;
  timeunit 1ns;
  timeprecision 1ps;
  import rwcl_pkg::*;

  // a chunk tag the parser should walk past
  localparam logic [31:0] TAG_LIST = 32'h5453_494c;

  // Tracks the parser state per accepted byte and holds the results it owes.
  class locator_scoreboard;
    rwcl_phase_t  phase;
    logic [1:0]   byte_slot;
    logic [31:0]  word_acc;
    logic [31:0]  remain;
    logic [31:0]  skip_left;
    logic [31:0]  pos;
    logic [31:0]  fmt_at;
    logic [31:0]  data_at;
    logic         have_fmt;
    logic         have_data;
    logic [1:0]   verdict;
    rwcl_result_t due_results[$];
    int           fails;

    function new();
      fails = 0;
      restart();
    endfunction

    function void restart();
      phase     = PH_RIFF;
      byte_slot = '0;
      word_acc  = '0;
      remain    = '0;
      skip_left = '0;
      pos       = '0;
      fmt_at    = '0;
      data_at   = '0;
      have_fmt  = 1'b0;
      have_data = 1'b0;
      verdict   = ST_SCAN;
    endfunction

    function void conclude(logic [1:0] code);
      verdict = code;
      phase   = PH_DONE;
    endfunction

    // Advance by one byte beat; returns 1 when the byte was parsed, not ignored.
    function bit absorb_byte(logic [7:0] b, logic first);
      logic [31:0]  at;
      logic [31:0]  w;
      bit           parsed;
      rwcl_result_t r;
      if (first) restart();
      parsed = (phase != PH_DONE);
      if (parsed) begin
        at  = pos;
        pos = pos + 32'd1;
        if (phase == PH_SKIP) begin
          skip_left = skip_left - 32'd1;
          if (skip_left == 32'd0) phase = PH_TAG;
        end else begin
          word_acc  = {b, word_acc[31:8]};
          byte_slot = byte_slot + 2'd1;
          if (byte_slot == 2'd0) begin
            w = word_acc;
            case (phase)
              PH_RIFF: begin
                if (w != TAG_RIFF) conclude(ST_BAD_TAG);
                else phase = PH_LEN;
              end
              PH_LEN: begin
                remain = w;
                phase  = PH_WAVE;
              end
              PH_WAVE: begin
                if (w != TAG_WAVE) conclude(ST_BAD_TAG);
                else if ($signed(remain) <= 0) conclude(ST_EXHAUST);
                else phase = PH_TAG;
              end
              PH_TAG: begin
                // header offset is where the tag word started
                if (w == TAG_FMT) begin
                  fmt_at   = at - 32'd3;
                  have_fmt = 1'b1;
                end else if (w == TAG_DATA) begin
                  data_at   = at - 32'd3;
                  have_data = 1'b1;
                end
                if (have_fmt && have_data) conclude(ST_FOUND);
                else phase = PH_SIZE;
              end
              PH_SIZE: begin
                remain    = remain - w;
                skip_left = w;
                if ($signed(remain) <= 0) conclude(ST_EXHAUST);
                else if (w == 32'd0) phase = PH_TAG;
                else phase = PH_SKIP;
              end
              default: conclude(ST_EXHAUST);
            endcase
          end
        end
      end
      r.status      = verdict;
      r.fmt_offset  = fmt_at;
      r.data_offset = data_at;
      r.fmt_valid   = have_fmt;
      r.data_valid  = have_data;
      due_results.push_back(r);
      return parsed;
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        fails++;
      end
    endfunction

    function void match_result(logic [71:0] beat);
      rwcl_result_t want;
      rwcl_result_t got;
      got = beat[67:0];
      if (due_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %0h", $time, beat);
        fails++;
        return;
      end
      want = due_results.pop_front();
      field_check("status", 32'(want.status), 32'(got.status));
      field_check("fmt_offset", want.fmt_offset, got.fmt_offset);
      field_check("data_offset", want.data_offset, got.data_offset);
      field_check("fmt_valid", 32'(want.fmt_valid), 32'(got.fmt_valid));
      field_check("data_valid", 32'(want.data_valid), 32'(got.data_valid));
      field_check("zero fill", 32'd0, 32'(beat[71:68]));
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'd0;
  logic [0:0]  in_tuser   = 1'b0;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [71:0] out_tdata;

  locator_scoreboard sb;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          sent_bytes = 0;
  logic [7:0]  file_bytes[$];

  riff_wave_chunk_locator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // receiver: stall at random, check every accepted result beat
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.match_result(out_tdata);
  end

  // one byte beat, with random idle cycles ahead of it
  task automatic send_byte(logic [7:0] b, logic first);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    void'(sb.absorb_byte(b, first));
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_file(bit mark_first);
    foreach (file_bytes[i]) send_byte(file_bytes[i], mark_first && i == 0);
    file_bytes.delete();
  endtask

  // little-endian word
  function automatic void add_word(logic [31:0] w);
    file_bytes.push_back(w[7:0]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(w[23:16]);
    file_bytes.push_back(w[31:24]);
  endfunction

  function automatic void add_body(int n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_header(logic [31:0] len);
    add_word(TAG_RIFF);
    add_word(len);
    add_word(TAG_WAVE);
  endfunction

  // Mostly well-formed files with random chunk lists; the rest corrupt headers or noise.
  function automatic void build_random_file();
    int          mode;
    int          n_chunks;
    int          idx;
    logic [31:0] tags[4];
    logic [31:0] sizes[4];
    logic [31:0] total;
    logic [31:0] len;
    mode = $urandom_range(99);
    if (mode < 80) begin
      n_chunks = $urandom_range(4);
      total = '0;
      for (int i = 0; i < n_chunks; i++) begin
        case ($urandom_range(9))
          0, 1, 2: tags[i] = TAG_FMT;
          3, 4, 5: tags[i] = TAG_DATA;
          6:       tags[i] = TAG_LIST;
          7:       tags[i] = $urandom;
          // near miss: one bit off a known tag
          default: tags[i] = ($urandom_range(1) ? TAG_FMT : TAG_DATA) ^
                             (32'd1 << $urandom_range(31));
        endcase
        idx = $urandom_range(19);
        if (idx < 4) sizes[i] = '0;
        else if (idx < 18) sizes[i] = $urandom_range(1, 12);
        else sizes[i] = $urandom;
        total = total + sizes[i];
      end
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: len = total + $urandom_range(1, 16);
        6:                len = total;
        7:                len = total - $urandom_range(8);
        8:                len = 32'h7fff_ffff;
        default:          len = {1'b1, 31'($urandom)};
      endcase
      add_header(len);
      for (int i = 0; i < n_chunks; i++) begin
        add_word(tags[i]);
        add_word(sizes[i]);
        // huge bodies are cut short; the next file restarts the parser if its first byte is marked
        add_body(sizes[i] <= 16 ? int'(sizes[i]) : $urandom_range(16));
      end
      add_body($urandom_range(6));
    end else if (mode < 90) begin
      // one bit flipped in the RIFF or WAVE tag
      add_header($urandom_range(1, 64));
      idx = $urandom_range(1) ? $urandom_range(3) : $urandom_range(8, 11);
      file_bytes[idx] = file_bytes[idx] ^ 8'(1 << $urandom_range(7));
      add_body($urandom_range(8));
    end else begin
      if ($urandom_range(1)) add_header($urandom_range(1, 100));
      add_body($urandom_range(1, 20));
    end
  endfunction

  initial begin
    int base;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // parser starts without a first-byte mark: bad RIFF tag, extreme byte values,
    // then a byte that must be ignored
    add_word(32'hff00_ff00);
    file_bytes.push_back(8'hff);
    send_file(1'b0);

    // zero length
    add_header(32'd0);
    send_file(1'b1);

    // bad WAVE tag wins over a negative length
    add_word(TAG_RIFF);
    add_word(32'h8000_0000);
    add_word(TAG_WAVE ^ 32'h0100_0000);
    send_file(1'b1);

    // duplicate fmt, zero-size chunks, then data completes the pair
    add_header(32'd100);
    add_word(TAG_FMT);
    add_word(32'd2);
    add_body(2);
    add_word(TAG_LIST);
    add_word(32'd0);
    add_word(TAG_FMT);
    add_word(32'd0);
    add_word(TAG_DATA);
    add_word(32'd8);
    send_file(1'b1);

    // length used up by a chunk body size
    add_header(32'd4);
    add_word(TAG_LIST);
    add_word(32'd4);
    add_body(4);
    send_file(1'b1);

    // random files through four pressure phases
    base = sent_bytes;
    while (sent_bytes - base < 1000) begin
      case ((sent_bytes - base) / 250)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 69;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 69;
        end
        default: begin
          idle_pct  = 32;
          stall_pct = 32;
        end
      endcase
      build_random_file();
      send_file($urandom_range(19) != 0);
    end

    in_tvalid <= 1'b0;
    stall_pct = 0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.fails == 0) begin
      $display("tb_riff_wave_chunk_locator passed");
    end else begin
      $display("tb_riff_wave_chunk_locator failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #800_000;
    $display("tb_riff_wave_chunk_locator failed");
    $finish;
  end

endmodule
